// File: rtl/dwmo_pkg.sv
// Shared types and constants of the min-aware deque: sizes, operation and
// status codes, controller states, and the command/status bundles.
// No dependencies.
`default_nettype none

package dwmo_pkg;

   localparam int DEPTH = 16;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_READ       = 3'd4,
      OP_DEL_MIN    = 3'd5,
      OP_SCALE_MIN  = 3'd6,
      OP_STATUS     = 3'd7
   } dwmo_op_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_RANGE = 2'd2,
      STAT_FULL  = 2'd3
   } dwmo_status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_SCAN_DRAIN,
      S_SHIFT_INIT,
      S_SHIFT,
      S_SHIFT_DRAIN,
      S_DROP,
      S_MUL,
      S_SCALE,
      S_SCALE_DRAIN,
      S_RESULT
   } dwmo_state_type;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_LOAD,
      ACT_PUSH,
      ACT_FETCH,
      ACT_CLEAR,
      ACT_SCAN,
      ACT_SHIFT_INIT,
      ACT_SHIFT,
      ACT_MUL,
      ACT_SCALE,
      ACT_DROP,
      ACT_RESULT
   } dwmo_act_type;

   // controller -> datapath
   typedef struct packed {
      dwmo_act_type act;
      logic         issue;   // read the entry at the scan index, advance it
      logic         check;   // latch the request's status code
   } dwmo_cmd_type;

   // datapath -> controller
   typedef struct packed {
      dwmo_op_type op;
      logic        fail;       // request would be refused
      logic        few;        // fewer than two entries
      logic        empty;
      logic        tail_none;  // last minimum sits at the back
      logic        at_last;    // scan index on the back entry
      logic        past;       // scan index beyond the back entry
   } dwmo_stat_type;

endpackage

`default_nettype wire

// File: rtl/dwmo_dp.sv
// Datapath of the min-aware deque: ring store, pointers, scan registers,
// multiplier and result registers. Driven by commands from dwmo_ctrl.
// Depends on dwmo_pkg.
`default_nettype none

module dwmo_dp
   import dwmo_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  dwmo_cmd_type         cmd,
   input  logic [2:0]           req_operation,
   input  logic signed [31:0]   req_value,
   input  logic [3:0]           req_position,
   input  logic signed [31:0]   req_factor,
   output dwmo_stat_type        stat,
   output logic signed [31:0]   rsp_data,
   output logic [CW-1:0]        rsp_count,
   output logic [1:0]           rsp_status
);

   function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                          input logic [CW-1:0] off);
      logic [CW:0] s;
      s = (CW+1)'(base) + (CW+1)'(off);
      if (s >= (CW+1)'(DEPTH)) begin
         s = s - (CW+1)'(DEPTH);
      end
      return s[AW-1:0];
   endfunction

   logic [31:0] mem_ff [DEPTH];
   logic [31:0] rdata_ff;

   dwmo_op_type     op_ff, op_in;
   logic [31:0]     val_ff, val_in;
   logic [3:0]      pos_ff, pos_in;
   logic [31:0]     fac_ff, fac_in;
   logic [AW-1:0]   front_ff, front_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   idx_ff, idx_in;
   logic            lag_ff, lag_in;
   logic [AW-1:0]   lag_idx_ff, lag_idx_in;
   logic [31:0]     min_ff, min_in;
   logic [AW-1:0]   last_ff, last_in;
   logic [31:0]     prod_ff, prod_in;
   dwmo_status_type st_ff, st_in, st_calc;
   logic [31:0]     out_data_ff, out_data_in;
   logic [CW-1:0]   out_count_ff, out_count_in;
   dwmo_status_type out_st_ff, out_st_in;

   logic            rd_en, wr_en;
   logic [AW-1:0]   rd_addr, wr_addr;
   logic [31:0]     wr_data;
   logic [31:0]     mul_w;
   logic [AW-1:0]   front_dec, front_inc;

   // low half of the product is the same for signed and unsigned operands
   assign mul_w     = min_ff * fac_ff;
   assign front_dec = (front_ff == '0) ? AW'(DEPTH - 1) : front_ff - AW'(1);
   assign front_inc = (front_ff == AW'(DEPTH - 1)) ? '0 : front_ff + AW'(1);

   always_comb begin
      unique case (op_ff)
         OP_PUSH_FRONT, OP_PUSH_BACK:
            st_calc = (count_ff == CW'(DEPTH)) ? STAT_FULL : STAT_OK;
         OP_POP_FRONT, OP_POP_BACK:
            st_calc = (count_ff == '0) ? STAT_EMPTY : STAT_OK;
         OP_READ:
            st_calc = (CW'(pos_ff) >= count_ff) ? STAT_RANGE : STAT_OK;
         default:
            st_calc = STAT_OK;
      endcase
   end

   assign stat.op        = op_ff;
   assign stat.fail      = (st_calc != STAT_OK);
   assign stat.few       = (count_ff <= CW'(1));
   assign stat.empty     = (count_ff == '0);
   assign stat.tail_none = ((CW'(last_ff) + CW'(1)) >= count_ff);
   assign stat.at_last   = (idx_ff == count_ff - CW'(1));
   assign stat.past      = (idx_ff >= count_ff);

   always_comb begin
      op_in        = op_ff;
      val_in       = val_ff;
      pos_in       = pos_ff;
      fac_in       = fac_ff;
      front_in     = front_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      min_in       = min_ff;
      last_in      = last_ff;
      prod_in      = prod_ff;
      st_in        = st_ff;
      out_data_in  = out_data_ff;
      out_count_in = out_count_ff;
      out_st_in    = out_st_ff;
      rd_en        = 1'b0;
      rd_addr      = front_ff;
      wr_en        = 1'b0;
      wr_addr      = front_ff;
      wr_data      = val_ff;
      lag_in       = cmd.issue;
      lag_idx_in   = idx_ff[AW-1:0];

      if (cmd.check) begin
         st_in = st_calc;
      end

      unique case (cmd.act)
         ACT_LOAD: begin
            op_in  = dwmo_op_type'(req_operation);
            val_in = req_value;
            pos_in = req_position;
            fac_in = req_factor;
         end
         ACT_PUSH: begin
            wr_en    = 1'b1;
            count_in = count_ff + CW'(1);
            if (op_ff == OP_PUSH_FRONT) begin
               front_in = front_dec;
               wr_addr  = front_dec;
            end else begin
               wr_addr  = slot(front_ff, count_ff);
            end
         end
         ACT_FETCH: begin
            rd_en = 1'b1;
            if (op_ff == OP_POP_FRONT) begin
               rd_addr  = front_ff;
               front_in = front_inc;
               count_in = count_ff - CW'(1);
            end else if (op_ff == OP_POP_BACK) begin
               rd_addr  = slot(front_ff, count_ff - CW'(1));
               count_in = count_ff - CW'(1);
            end else begin
               rd_addr  = slot(front_ff, CW'(pos_ff));
            end
         end
         ACT_CLEAR: begin
            idx_in = '0;
         end
         ACT_SCAN: begin
            // running minimum; ties move the last-occurrence mark back
            if (lag_ff) begin
               if (lag_idx_ff == '0 || $signed(rdata_ff) < $signed(min_ff)) begin
                  min_in  = rdata_ff;
                  last_in = lag_idx_ff;
               end else if (rdata_ff == min_ff) begin
                  last_in = lag_idx_ff;
               end
            end
         end
         ACT_SHIFT_INIT: begin
            idx_in = CW'(last_ff) + CW'(2);
         end
         ACT_SHIFT: begin
            // move each entry one place toward the front
            if (lag_ff) begin
               wr_en   = 1'b1;
               wr_addr = slot(front_ff, CW'(lag_idx_ff) - CW'(1));
               wr_data = rdata_ff;
            end
         end
         ACT_MUL: begin
            prod_in = mul_w;
            idx_in  = '0;
         end
         ACT_SCALE: begin
            if (lag_ff && rdata_ff == min_ff) begin
               wr_en   = 1'b1;
               wr_addr = slot(front_ff, CW'(lag_idx_ff));
               wr_data = prod_ff;
            end
         end
         ACT_DROP: begin
            count_in = count_ff - CW'(1);
         end
         ACT_RESULT: begin
            out_count_in = count_ff;
            out_st_in    = st_ff;
            if ((op_ff == OP_POP_FRONT || op_ff == OP_POP_BACK || op_ff == OP_READ)
                && st_ff == STAT_OK) begin
               out_data_in = rdata_ff;
            end else begin
               out_data_in = '0;
            end
         end
         default: begin
         end
      endcase

      if (cmd.issue) begin
         rd_en   = 1'b1;
         rd_addr = slot(front_ff, idx_ff);
         idx_in  = idx_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
         idx_ff   <= '0;
         lag_ff   <= 1'b0;
      end else begin
         front_ff <= front_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         lag_ff   <= lag_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      val_ff       <= val_in;
      pos_ff       <= pos_in;
      fac_ff       <= fac_in;
      lag_idx_ff   <= lag_idx_in;
      min_ff       <= min_in;
      last_ff      <= last_in;
      prod_ff      <= prod_in;
      st_ff        <= st_in;
      out_data_ff  <= out_data_in;
      out_count_ff <= out_count_in;
      out_st_ff    <= out_st_in;
   end

   assign rsp_data   = out_data_ff;
   assign rsp_count  = out_count_ff;
   assign rsp_status = out_st_ff;

endmodule

`default_nettype wire

// File: rtl/dwmo_ctrl.sv
// Controller of the min-aware deque: sequences each request through the
// datapath and owns both handshakes. Depends on dwmo_pkg.
`default_nettype none

module dwmo_ctrl
   import dwmo_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dwmo_stat_type stat,
   output dwmo_cmd_type  cmd
);

   dwmo_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           load;

   assign load = (state_ff == S_RESULT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:
            if (req_valid) begin
               state_in = S_EXEC;
            end
         S_EXEC: begin
            unique case (stat.op)
               OP_DEL_MIN:   state_in = stat.few ? S_RESULT : S_SCAN;
               OP_SCALE_MIN: state_in = stat.empty ? S_RESULT : S_SCAN;
               default:      state_in = S_RESULT;
            endcase
         end
         S_SCAN:
            if (stat.at_last) begin
               state_in = S_SCAN_DRAIN;
            end
         S_SCAN_DRAIN:
            state_in = (stat.op == OP_DEL_MIN) ? S_SHIFT_INIT : S_MUL;
         S_SHIFT_INIT:
            state_in = stat.tail_none ? S_RESULT : S_SHIFT;
         S_SHIFT: begin
            priority if (stat.past) begin
               state_in = S_DROP;
            end else if (stat.at_last) begin
               state_in = S_SHIFT_DRAIN;
            end
         end
         S_SHIFT_DRAIN: state_in = S_DROP;
         S_DROP:        state_in = S_RESULT;
         S_MUL:         state_in = S_SCALE;
         S_SCALE:
            if (stat.at_last) begin
               state_in = S_SCALE_DRAIN;
            end
         S_SCALE_DRAIN: state_in = S_RESULT;
         S_RESULT:
            if (load) begin
               state_in = S_IDLE;
            end
         default:       state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.act   = ACT_NONE;
      cmd.issue = 1'b0;
      cmd.check = 1'b0;
      unique case (state_ff)
         S_IDLE:
            if (req_valid) begin
               cmd.act = ACT_LOAD;
            end
         S_EXEC: begin
            cmd.check = 1'b1;
            unique case (stat.op)
               OP_PUSH_FRONT, OP_PUSH_BACK:
                  cmd.act = stat.fail ? ACT_NONE : ACT_PUSH;
               OP_POP_FRONT, OP_POP_BACK, OP_READ:
                  cmd.act = stat.fail ? ACT_NONE : ACT_FETCH;
               OP_DEL_MIN:
                  cmd.act = stat.few ? ACT_NONE : ACT_CLEAR;
               OP_SCALE_MIN:
                  cmd.act = stat.empty ? ACT_NONE : ACT_CLEAR;
               default:
                  cmd.act = ACT_NONE;
            endcase
         end
         S_SCAN: begin
            cmd.act   = ACT_SCAN;
            cmd.issue = 1'b1;
         end
         S_SCAN_DRAIN:  cmd.act = ACT_SCAN;
         S_SHIFT_INIT:  cmd.act = ACT_SHIFT_INIT;
         S_SHIFT: begin
            cmd.act   = ACT_SHIFT;
            cmd.issue = !stat.past;
         end
         S_SHIFT_DRAIN: cmd.act = ACT_SHIFT;
         S_DROP:        cmd.act = ACT_DROP;
         S_MUL:         cmd.act = ACT_MUL;
         S_SCALE: begin
            cmd.act   = ACT_SCALE;
            cmd.issue = 1'b1;
         end
         S_SCALE_DRAIN: cmd.act = ACT_SCALE;
         S_RESULT:
            if (load) begin
               cmd.act = ACT_RESULT;
            end
         default:       cmd.act = ACT_NONE;
      endcase
   end

   assign rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: rtl/deque_with_min_operations.sv
// Top level of the min-aware double-ended queue.
// Depends on dwmo_pkg, dwmo_ctrl and dwmo_dp.
//
// Usage:
//  - Request channel (req_*): operation, value, position, factor. A request
//    is taken at a clock edge with req_valid high and req_stall low.
//    req_stall is high while a request is in flight.
//  - Response channel (rsp_*): exactly one response per request, carrying
//    data (popped or read value, else zero), count after the operation and
//    status (ok, empty, index out of range, full).
//  - The min operations walk the ring store twice through its single read
//    port, one entry per cycle: a scan for the minimum, then a shift or a
//    scaling pass. A new request is taken only once the previous one has
//    finished and its response has gone into the output register.
//  - The response sits in an output register: while rsp_stall holds it,
//    the next request is still taken and worked on; its result waits.
//  - Reset (synchronous, active high) empties the queue and drops any
//    pending response. Stored values are not cleared.
`default_nettype none

module deque_with_min_operations
   import dwmo_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_operation,
   input  logic signed [31:0]  req_value,
   input  logic [3:0]          req_position,
   input  logic signed [31:0]  req_factor,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_data,
   output logic [4:0]          rsp_count,
   output logic [1:0]          rsp_status
);

   dwmo_cmd_type  cmd;
   dwmo_stat_type stat;

   // sequence each request: check, then single ops or scan/shift/scale passes
   dwmo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // hold the ring store, pointers, running minimum and response registers
   dwmo_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_operation (req_operation),
      .req_value     (req_value),
      .req_position  (req_position),
      .req_factor    (req_factor),
      .stat          (stat),
      .rsp_data      (rsp_data),
      .rsp_count     (rsp_count),
      .rsp_status    (rsp_status)
   );

endmodule

`default_nettype wire

// File: rtl/dwmo_chk.sv
// Port-level checker for the min-aware deque, bound to the top level.
// Depends on dwmo_pkg.
`default_nettype none

module dwmo_chk
   import dwmo_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [2:0]         req_operation,
   input  logic signed [31:0] req_value,
   input  logic [3:0]         req_position,
   input  logic signed [31:0] req_factor,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [31:0] rsp_data,
   input  logic [4:0]         rsp_count,
   input  logic [1:0]         rsp_status
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data)
         && $stable(rsp_count) && $stable(rsp_status))
      else $error("stalled response changed");

   // no response in the cycle after a reset edge
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // refused requests return zero data
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |-> rsp_data == '0)
      else $error("nonzero data with error status");

   // full and empty flags agree with the count
   a_flag_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != STAT_FULL || rsp_count == 5'(DEPTH))
         && (rsp_status != STAT_EMPTY || rsp_count == '0)
         && rsp_count <= 5'(DEPTH))
      else $error("status flag disagrees with count");

endmodule

bind deque_with_min_operations dwmo_chk u_dwmo_chk (.*);

`default_nettype wire

// File: verif/deque_with_min_operations_tb.sv
// Self-checking testbench for the min-aware deque: directed and random
// request streams, a bit-accurate deque model, random idling on both sides.
// Depends on dwmo_pkg and the deque_with_min_operations RTL.
`default_nettype none

module deque_with_min_operations_tb
   import dwmo_pkg::*;
();

   localparam int CYCLE_LIMIT   = 300000;
   localparam int DRAIN_CYCLES  = 60;
   localparam int RANDOM_TARGET = 550;

   typedef struct packed {
      dwmo_op_type        op;
      logic signed [31:0] value;
      logic [3:0]         position;
      logic signed [31:0] factor;
   } deque_request_type;

   typedef struct packed {
      logic signed [31:0] data;
      logic [4:0]         count;
      dwmo_status_type    status;
   } deque_response_type;

   // DUT ports; the inputs are known from time zero
   logic               clock         = 1'b0;
   logic               reset         = 1'b1;
   logic               req_valid     = 1'b0;
   logic               req_stall;
   logic [2:0]         req_operation = OP_STATUS;
   logic signed [31:0] req_value     = '0;
   logic [3:0]         req_position  = '0;
   logic signed [31:0] req_factor    = '0;
   logic               rsp_valid;
   logic               rsp_stall     = 1'b0;
   logic signed [31:0] rsp_data;
   logic [4:0]         rsp_count;
   logic [1:0]         rsp_status;

   // stimulus and scoreboard state
   deque_request_type  request_backlog[$];
   deque_response_type awaited_responses[$];
   deque_request_type  presented_request = '0;
   int                 total_requests    = 0;
   int                 accepted_count    = 0;
   int                 response_index    = 0;
   int                 mismatch_count    = 0;
   int                 cycle_count       = 0;
   int                 send_idle_pct;
   int                 recv_idle_pct;

   // deque model: ring store, front pointer, live count
   logic signed [31:0] model_store [DEPTH];
   logic [AW-1:0]      model_front = '0;
   int unsigned        model_fill  = 0;

   deque_with_min_operations dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_value     (req_value),
      .req_position  (req_position),
      .req_factor    (req_factor),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .rsp_count     (rsp_count),
      .rsp_status    (rsp_status)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Idle profile follows progress: sender light / receiver heavy, then the
   // reverse, then a final stretch with no idling at all.
   assign send_idle_pct = (accepted_count < total_requests / 3)     ? 11 :
                          (accepted_count < 2 * total_requests / 3) ? 69 : 0;
   assign recv_idle_pct = (accepted_count < total_requests / 3)     ? 69 :
                          (accepted_count < 2 * total_requests / 3) ? 11 : 0;

   // ---------------------------------------------------------------------
   // Model
   // ---------------------------------------------------------------------

   // Map an index counted from the front onto the ring.
   function automatic logic [AW-1:0] ring_slot(int unsigned idx);
      return model_front + AW'(idx);
   endfunction

   // Smallest live value, signed compare.
   function automatic logic signed [31:0] lowest_live();
      logic signed [31:0] m;
      m = model_store[ring_slot(0)];
      for (int unsigned i = 1; i < model_fill; i++) begin
         if (model_store[ring_slot(i)] < m) begin
            m = model_store[ring_slot(i)];
         end
      end
      return m;
   endfunction

   // Apply one accepted request to the model and queue the response it owes.
   task automatic apply_to_model(input deque_request_type rq);
      deque_response_type rs;
      logic signed [31:0] lowest;
      int unsigned        last_low;
      rs.data   = '0;
      rs.status = STAT_OK;
      case (rq.op)
         OP_PUSH_FRONT: begin
            if (model_fill >= DEPTH) begin
               rs.status = STAT_FULL;
            end else begin
               model_front = model_front - 1'b1;
               model_store[model_front] = rq.value;
               model_fill++;
            end
         end
         OP_PUSH_BACK: begin
            if (model_fill >= DEPTH) begin
               rs.status = STAT_FULL;
            end else begin
               model_store[ring_slot(model_fill)] = rq.value;
               model_fill++;
            end
         end
         OP_POP_FRONT: begin
            if (model_fill == 0) begin
               rs.status = STAT_EMPTY;
            end else begin
               rs.data = model_store[model_front];
               model_front = model_front + 1'b1;
               model_fill--;
            end
         end
         OP_POP_BACK: begin
            if (model_fill == 0) begin
               rs.status = STAT_EMPTY;
            end else begin
               rs.data = model_store[ring_slot(model_fill - 1)];
               model_fill--;
            end
         end
         OP_READ: begin
            if (rq.position >= model_fill) begin
               rs.status = STAT_RANGE;
            end else begin
               rs.data = model_store[ring_slot(rq.position)];
            end
         end
         OP_DEL_MIN: begin
            // drop the entry just behind the last minimum, close the gap
            if (model_fill > 1) begin
               lowest   = lowest_live();
               last_low = 0;
               for (int unsigned i = 0; i < model_fill; i++) begin
                  if (model_store[ring_slot(i)] == lowest) begin
                     last_low = i;
                  end
               end
               if (last_low + 1 < model_fill) begin
                  for (int unsigned i = last_low + 1; i + 1 < model_fill; i++) begin
                     model_store[ring_slot(i)] = model_store[ring_slot(i + 1)];
                  end
                  model_fill--;
               end
            end
         end
         OP_SCALE_MIN: begin
            // product kept at 32 bits, so overflow wraps
            if (model_fill > 0) begin
               lowest = lowest_live();
               for (int unsigned i = 0; i < model_fill; i++) begin
                  if (model_store[ring_slot(i)] == lowest) begin
                     model_store[ring_slot(i)] = lowest * rq.factor;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      rs.count = 5'(model_fill);
      awaited_responses.insert(awaited_responses.size(), rs);
   endtask

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Mix small values (to force duplicate minima), extremes and full range.
   function automatic logic signed [31:0] pick_value();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 40) begin
         return $signed($urandom_range(6)) - 32'sd3;
      end else if (sel < 50) begin
         return 32'sh8000_0000;
      end else if (sel < 58) begin
         return 32'sh7fff_ffff;
      end else begin
         return $urandom;
      end
   endfunction

   function automatic logic signed [31:0] pick_factor();
      case ($urandom_range(6))
         0:       return -32'sd1;
         1:       return 32'sd0;
         2:       return 32'sd1;
         3:       return 32'sd2;
         4:       return $signed($urandom_range(8)) - 32'sd4;
         default: return $urandom;
      endcase
   endfunction

   // Build a request; fields the operation does not use are still random.
   function automatic deque_request_type make_request(dwmo_op_type op);
      deque_request_type rq;
      rq.op       = op;
      rq.value    = pick_value();
      rq.position = 4'($urandom_range(15));
      rq.factor   = pick_factor();
      return rq;
   endfunction

   task automatic queue_request(dwmo_op_type op, logic signed [31:0] v,
                                logic [3:0] p, logic signed [31:0] f);
      deque_request_type rq;
      rq.op       = op;
      rq.value    = v;
      rq.position = p;
      rq.factor   = f;
      request_backlog.insert(request_backlog.size(), rq);
   endtask

   task automatic flag_mismatch(input string what);
      $display("MISMATCH at response %0d: %s", response_index, what);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------------
   // Driver: present backlog requests, predict on acceptance
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive_requests
      logic              nxt_valid;
      deque_request_type nxt;
      nxt_valid = req_valid;
      nxt       = presented_request;
      if (reset) begin
         nxt_valid = 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_to_model(presented_request);
            accepted_count <= accepted_count + 1;
            nxt_valid = 1'b0;
         end
         // hold a stalled request as is; only refill once the slot is free
         if (!nxt_valid && request_backlog.size() > 0 &&
             $urandom_range(99) >= send_idle_pct) begin
            nxt       = request_backlog[0];
            request_backlog.delete(0);
            nxt_valid = 1'b1;
         end
      end
      presented_request <= nxt;
      req_valid         <= nxt_valid;
      req_operation     <= nxt.op;
      req_value         <= nxt.value;
      req_position      <= nxt.position;
      req_factor        <= nxt.factor;
   end

   // ---------------------------------------------------------------------
   // Monitor: check each accepted response against the oldest prediction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_responses
      deque_response_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_responses.size() == 0) begin
               flag_mismatch("response with no request outstanding");
            end else begin
               want = awaited_responses[0];
               awaited_responses.delete(0);
               if (rsp_data !== want.data) begin
                  flag_mismatch($sformatf("data got %0d want %0d", rsp_data, want.data));
               end
               if (rsp_count !== want.count) begin
                  flag_mismatch($sformatf("count got %0d want %0d", rsp_count, want.count));
               end
               if (rsp_status !== want.status) begin
                  flag_mismatch($sformatf("status got %0d want %0d",
                                          rsp_status, want.status));
               end
            end
            response_index++;
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus, end of run
   // ---------------------------------------------------------------------
   initial begin : run_regression
      int unsigned random_count;
      int unsigned burst_len;
      int unsigned sel;
      dwmo_op_type op;

      // Directed: every operation but push-front on an empty queue first.
      queue_request(OP_STATUS,     32'sd0, 4'd0,  32'sd0);
      queue_request(OP_POP_FRONT,  32'sd1, 4'd0,  32'sd0);
      queue_request(OP_POP_BACK,   32'sd2, 4'd0,  32'sd0);
      queue_request(OP_READ,       32'sd0, 4'd0,  32'sd0);    // range on empty
      queue_request(OP_DEL_MIN,    32'sd0, 4'd0,  32'sd0);
      queue_request(OP_SCALE_MIN,  32'sd0, 4'd0,  32'sd5);    // scale on empty
      queue_request(OP_PUSH_BACK,  32'sh7fff_ffff, 4'd0, 32'sd0);
      queue_request(OP_DEL_MIN,    32'sd0, 4'd0,  32'sd0);    // one entry only
      queue_request(OP_PUSH_FRONT, 32'sh8000_0000, 4'd15, -32'sd1);
      queue_request(OP_READ,       32'sd0, 4'd1,  32'sd0);
      queue_request(OP_READ,       32'sd0, 4'd15, 32'sd0);    // index too high
      queue_request(OP_SCALE_MIN,  32'sd0, 4'd0,  -32'sd1);   // wraps to itself
      queue_request(OP_PUSH_BACK,  32'sd5, 4'd0,  32'sd0);
      queue_request(OP_DEL_MIN,    32'sd0, 4'd0,  32'sd0);    // removes the max
      queue_request(OP_PUSH_BACK,  32'sh8000_0000, 4'd0, 32'sd0);
      queue_request(OP_DEL_MIN,    32'sd0, 4'd0,  32'sd0);    // last min at back
      queue_request(OP_SCALE_MIN,  32'sd0, 4'd0,  32'sd2);    // overflow to zero
      queue_request(OP_SCALE_MIN,  32'sd0, 4'd0,  32'sh7fff_ffff);
      queue_request(OP_READ,       32'sd0, 4'd0,  32'sd0);
      queue_request(OP_READ,       32'sd0, 4'd2,  32'sd0);

      // Random: open with a fill past full, then mixed bursts.
      random_count = 0;
      for (int i = 0; i < 20; i++) begin
         request_backlog.insert(request_backlog.size(),
                                make_request(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK));
      end
      queue_request(OP_READ, 32'sd0, 4'd15, 32'sd0);
      random_count += 21;

      while (random_count < RANDOM_TARGET) begin
         sel       = $urandom_range(99);
         burst_len = $urandom_range(25, 8);
         for (int unsigned j = 0; j < burst_len; j++) begin
            if (sel < 25) begin
               // fill toward full
               op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
            end else if (sel < 45) begin
               // drain toward empty, with some reads
               case ($urandom_range(4))
                  0:       op = OP_READ;
                  1, 2:    op = OP_POP_FRONT;
                  default: op = OP_POP_BACK;
               endcase
            end else if (sel < 85) begin
               // min work on a populated queue
               case ($urandom_range(19))
                  0, 1, 2, 3, 4, 5, 6, 7: op = $urandom_range(1) ? OP_PUSH_FRONT
                                                                : OP_PUSH_BACK;
                  8, 9, 10, 11, 12:       op = OP_DEL_MIN;
                  13, 14, 15:             op = OP_SCALE_MIN;
                  16, 17:                 op = OP_READ;
                  18:                     op = OP_STATUS;
                  default:                op = $urandom_range(1) ? OP_POP_FRONT
                                                                : OP_POP_BACK;
               endcase
            end else begin
               // noise: any operation
               op = dwmo_op_type'($urandom_range(7));
            end
            request_backlog.insert(request_backlog.size(), make_request(op));
         end
         random_count += burst_len;
      end
      total_requests = request_backlog.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // wait for the last request to go in and its response to come back
      while (request_backlog.size() > 0 || req_valid || awaited_responses.size() > 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("deque_with_min_operations regression: pass");
      end else begin
         $display("deque_with_min_operations regression: fail");
      end
      $finish;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
      end
      $display("TIMEOUT after %0d cycles", cycle_count);
      $display("deque_with_min_operations regression: fail");
      $finish;
   end

endmodule

`default_nettype wire

// File: filelist.f
rtl/dwmo_pkg.sv
rtl/dwmo_dp.sv
rtl/dwmo_ctrl.sv
rtl/deque_with_min_operations.sv
rtl/dwmo_chk.sv
verif/deque_with_min_operations_tb.sv
